@@ design/fir_filter_64_tap_defines.svh @@
// Assertion macros for the FIR filter. Build with SYNTH defined to drop them.
`ifndef FIR_FILTER_64_TAP_DEFINES_SVH
`define FIR_FILTER_64_TAP_DEFINES_SVH
`ifndef SYNTH
// check while out of reset
`define FIR_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("fir_filter_64_tap: assertion failed");
// check at every edge, reset included
`define FIR_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("fir_filter_64_tap: assertion failed");
`else
`define FIR_ASSERT(lbl, prop)
`define FIR_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

@@ design/fir64_pkg.sv @@
`default_nettype none
package fir64_pkg;

    localparam int TAPS           = 64;
    localparam int SAMPLE_BITS    = 12;
    localparam int COEF_BITS      = 16;
    localparam int COEF_FRAC_BITS = 15;
    localparam int OUT_BITS       = 16;
    localparam int PROD_BITS      = SAMPLE_BITS + 1 + COEF_BITS;
    // sum of |coef| * 4095 stays below 2^28; keep a bit of margin
    localparam int ACC_BITS       = 30;
    localparam int ROM_TAPS       = 64;
    localparam int ROM_HALF_TAPS  = 32;

    typedef logic        [SAMPLE_BITS-1:0] t_sample;
    typedef logic signed [COEF_BITS-1:0]   t_coef;
    typedef logic signed [PROD_BITS-1:0]   t_prod;
    typedef logic signed [ACC_BITS-1:0]    t_acc;
    typedef logic signed [OUT_BITS-1:0]    t_filtered;

    localparam t_acc ACC_HALF = t_acc'(1) <<< (COEF_FRAC_BITS - 1);
    localparam t_acc SAT_MAX  = t_acc'((1 << (OUT_BITS - 1)) - 1);
    localparam t_acc SAT_MIN  = -t_acc'(1 << (OUT_BITS - 1));

    localparam t_coef ROM_HALF [ROM_HALF_TAPS] = '{
        -16'sd4444,  16'sd298,   16'sd352,   16'sd440,
         16'sd549,   16'sd668,   16'sd782,   16'sd878,
         16'sd943,   16'sd967,   16'sd942,   16'sd869,
         16'sd746,   16'sd582,   16'sd385,   16'sd172,
        -16'sd45,   -16'sd245,  -16'sd417,  -16'sd543,
        -16'sd618,  -16'sd620,  -16'sd569,  -16'sd462,
        -16'sd301,  -16'sd106,   16'sd111,   16'sd329,
         16'sd531,   16'sd700,   16'sd821,   16'sd884
    };

    // symmetric ROM: fold the upper half onto the lower
    function automatic t_coef coef_at(input int unsigned k);
        int unsigned idx;
        idx = (k < ROM_HALF_TAPS) ? k : (ROM_TAPS - 1 - k);
        if (k >= ROM_TAPS) begin
            return '0;
        end
        return ROM_HALF[idx[4:0]];
    endfunction

endpackage
`default_nettype wire

@@ design/fir64_if.sv @@
`default_nettype none
interface fir64_sample_if import fir64_pkg::*; ();
    logic    valid;
    logic    ready;
    t_sample sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface fir64_result_if import fir64_pkg::*; ();
    logic      valid;
    logic      ready;
    t_filtered filtered;
    logic      saturated;

    modport source (output valid, output filtered, output saturated, input ready);
    modport sink   (input valid, input filtered, input saturated, output ready);
endinterface
`default_nettype wire

@@ design/fir_filter_64_tap.sv @@
// Channel   Dir  Payload                            Beat when
// i_in      in   sample (12b unsigned)              i_in.valid && i_in.ready
// o_out     out  filtered (16b signed), saturated   o_out.valid && o_out.ready
//
// Transposed FIR: 64 cells each hold one partial sum and advance on every
// input beat, so the full sum for a sample sits in cell 0 in the following cycle.
// Output valid comes from the output register; one sample per clock while the output is not stalled.
// Round and saturate sit between cell 0 and the output register.
// Synchronous active-low reset clears all partial sums (an all-zero history).
// A stalled output holds one result in cell 0 and one in the output register.
`default_nettype none
`include "fir_filter_64_tap_defines.svh"
module fir_filter_64_tap import fir64_pkg::*; (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    fir64_sample_if.sink      i_in,
    fir64_result_if.source    o_out
);

    t_acc      w_psum [TAPS+1];
    logic      w_in_beat;
    logic      w_move;
    t_acc      w_round;
    t_acc      w_q;
    logic      w_sat;
    t_filtered w_filtered;

    logic      r_pend;
    logic      r_out_valid;
    t_filtered r_filtered;
    logic      r_saturated;

    assign w_psum[TAPS] = '0;

    for (genvar k = 0; k < TAPS; k++) begin : g_cell
        fir64_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (w_in_beat),
            .i_sample (i_in.sample),
            .i_coef   (coef_at(k)),
            .i_psum   (w_psum[k+1]),
            .o_psum   (w_psum[k])
        );
    end

    // cell 0 result moves out when the output register is free or draining
    assign w_move    = r_pend && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_pend || w_move;
    assign w_in_beat = i_in.valid && i_in.ready;

    // add half then floor: ties go toward plus infinity
    always_comb begin
        w_round = w_psum[0] + ACC_HALF;
        w_q     = w_round >>> COEF_FRAC_BITS;
        w_sat   = 1'b0;
        if (w_q > SAT_MAX) begin
            w_filtered = SAT_MAX[OUT_BITS-1:0];
            w_sat      = 1'b1;
        end else if (w_q < SAT_MIN) begin
            w_filtered = SAT_MIN[OUT_BITS-1:0];
            w_sat      = 1'b1;
        end else begin
            w_filtered = w_q[OUT_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_beat) begin
                r_pend <= 1'b1;
            end else if (w_move) begin
                r_pend <= 1'b0;
            end
            if (w_move) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_filtered  <= w_filtered;
            r_saturated <= w_sat;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.filtered  = r_filtered;
    assign o_out.saturated = r_saturated;

    `FIR_ASSERT(a_no_overrun, (r_pend && r_out_valid && !o_out.ready) |-> !i_in.ready)
    `FIR_ASSERT(a_beat_pends, (i_in.valid && i_in.ready) |=> r_pend)
    `FIR_ASSERT(a_sat_clips, (o_out.valid && o_out.saturated) |->
        (o_out.filtered == 16'sh7fff || o_out.filtered == 16'sh8000))
    `FIR_ASSERT_ALWAYS(a_rst_clear, !i_rst_n |=> (!r_pend && !r_out_valid))

endmodule
`default_nettype wire

@@ design/fir64_cell.sv @@
`default_nettype none
// One tap of the transposed-form chain: multiply the broadcast sample by
// this tap's coefficient and add the partial sum from the next cell.
module fir64_cell import fir64_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_en,
    input  wire t_sample i_sample,
    input  wire t_coef   i_coef,
    input  wire t_acc    i_psum,
    output t_acc         o_psum
);

    t_acc  r_psum;
    t_acc  n_psum;
    t_prod w_prod;

    always_comb begin
        w_prod = $signed({1'b0, i_sample}) * i_coef;
        n_psum = i_psum + t_acc'(w_prod);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_psum <= '0;
        end else if (i_en) begin
            r_psum <= n_psum;
        end
    end

    assign o_psum = r_psum;

endmodule
`default_nettype wire

@@ test/tb_fir_filter_64_tap.sv @@
`timescale 1ns / 1ps
module tb_fir_filter_64_tap;
    import fir64_pkg::*;

    localparam int ITEM_COUNT    = 850;
    localparam int IDLE_LIMIT    = 2000;
    localparam int HOLDOFF_BEATS = 200;
    localparam int HOLDOFF_LEN   = 160;
    localparam int DRAIN_CYCLES  = 8;
    localparam int DIRECTED_ROWS = 20;

    // lower half of the symmetric low-pass set, signed Q1.15
    localparam int LOWPASS_HALF [TAPS/2] = '{
        -4444,  298,  352,  440,  549,  668,  782,  878,
          943,  967,  942,  869,  746,  582,  385,  172,
          -45, -245, -417, -543, -618, -620, -569, -462,
         -301, -106,  111,  329,  531,  700,  821,  884
    };

    typedef struct packed {
        t_filtered filtered;
        logic      saturated;
    } filter_out_t;

    typedef struct packed {
        t_sample   sample;
        logic      typed;
        t_filtered filtered;
    } stim_row_t;

    typedef enum int {
        MODE_UNIFORM,
        MODE_EXTREME,
        MODE_SMALL,
        MODE_CONSTANT,
        MODE_TOGGLE
    } stim_mode_t;

    // impulse, steps and bit patterns; first two outputs are known after reset
    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{12'h000, 1'b1, 16'sd0},
        '{12'hFFF, 1'b1, -16'sd555},
        '{12'h000, 1'b0, 16'sd0},
        '{12'h000, 1'b0, 16'sd0},
        '{12'hFFF, 1'b0, 16'sd0},
        '{12'hFFF, 1'b0, 16'sd0},
        '{12'hFFF, 1'b0, 16'sd0},
        '{12'hFFF, 1'b0, 16'sd0},
        '{12'h001, 1'b0, 16'sd0},
        '{12'h800, 1'b0, 16'sd0},
        '{12'h7FF, 1'b0, 16'sd0},
        '{12'hAAA, 1'b0, 16'sd0},
        '{12'h555, 1'b0, 16'sd0},
        '{12'hFFE, 1'b0, 16'sd0},
        '{12'hFFF, 1'b0, 16'sd0},
        '{12'h000, 1'b0, 16'sd0},
        '{12'h800, 1'b0, 16'sd0},
        '{12'h7FF, 1'b0, 16'sd0},
        '{12'h001, 1'b0, 16'sd0},
        '{12'h000, 1'b0, 16'sd0}
    };

    logic clk = 1'b0;
    logic rst_n;

    fir64_sample_if sample_ch ();
    fir64_result_if result_ch ();

    fir_filter_64_tap u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (sample_ch),
        .o_out   (result_ch)
    );

    always #4 clk = ~clk;

    t_sample     sample_hist [TAPS] = '{default: '0};
    filter_out_t filtered_due_q [$];
    logic        typed_flag;
    t_filtered   typed_value;
    int          n_errors    = 0;
    int          n_sent      = 0;
    int          n_results   = 0;
    int          burst_left  = 1;
    int          idle_cycles = 0;

    function automatic filter_out_t filter_step(input t_sample s);
        longint      acc;
        longint      q;
        filter_out_t r;
        for (int k = TAPS - 1; k > 0; k--) begin
            sample_hist[k] = sample_hist[k-1];
        end
        sample_hist[0] = s;
        acc = 0;
        for (int k = 0; k < TAPS; k++) begin
            acc += longint'(k < TAPS/2 ? LOWPASS_HALF[k] : LOWPASS_HALF[TAPS-1-k])
                 * longint'(sample_hist[k]);
        end
        // add half, then floor: ties go toward plus infinity
        q = (acc + (longint'(1) << (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
        r.saturated = 1'b0;
        if (q > 32767) begin
            q = 32767;
            r.saturated = 1'b1;
        end else if (q < -32768) begin
            q = -32768;
            r.saturated = 1'b1;
        end
        r.filtered = t_filtered'(q);
        return r;
    endfunction

    task automatic report(input string msg);
        n_errors++;
        if (n_errors <= 10) begin
            $display("[%0t] %s", $time, msg);
        end
    endtask

    // predict on each input beat, check on each output beat
    always @(posedge clk) begin
        filter_out_t due;
        if (rst_n) begin
            if (sample_ch.valid && sample_ch.ready) begin
                due = filter_step(sample_ch.sample);
                if (typed_flag) begin
                    due.filtered  = typed_value;
                    due.saturated = 1'b0;
                end
                filtered_due_q.push_back(due);
            end
            if (result_ch.valid && result_ch.ready) begin
                n_results <= n_results + 1;
                if (filtered_due_q.size() == 0) begin
                    report($sformatf("unexpected result filtered=%0d saturated=%0b",
                                     result_ch.filtered, result_ch.saturated));
                end else begin
                    due = filtered_due_q.pop_front();
                    if (result_ch.filtered !== due.filtered) begin
                        report($sformatf("result %0d filtered: expected %0d, got %0d",
                                         n_results, due.filtered, result_ch.filtered));
                    end
                    if (result_ch.saturated !== due.saturated) begin
                        report($sformatf("result %0d saturated: expected %0b, got %0b",
                                         n_results, due.saturated, result_ch.saturated));
                    end
                end
            end
        end
    end

    always @(posedge clk) begin
        if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // receiver: rotating stall pattern, plus one long hold-off
    initial begin
        logic [15:0] stall_pattern;
        int          phase_left;
        bit          held_off;
        stall_pattern = 16'hFFFF;
        phase_left    = 0;
        held_off      = 1'b0;
        result_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (!held_off && n_results >= HOLDOFF_BEATS) begin
                held_off = 1'b1;
                result_ch.ready <= 1'b0;
                repeat (HOLDOFF_LEN) @(posedge clk);
            end else begin
                if (phase_left == 0) begin
                    phase_left    = $urandom_range(20, 100);
                    stall_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                                : 16'($urandom) | 16'h0101;
                end
                phase_left--;
                result_ch.ready <= stall_pattern[0];
                stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
            end
        end
    end

    task automatic send_sample(input t_sample s, input logic typed, input t_filtered val);
        int gap;
        sample_ch.valid  <= 1'b1;
        sample_ch.sample <= s;
        typed_flag       <= typed;
        typed_value      <= val;
        @(posedge clk);
        while (!sample_ch.ready) @(posedge clk);
        n_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap        = $urandom_range(0, 12);
            if (gap > 0) begin
                sample_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // stop offering and hold until every beat in flight has come out
    task automatic wait_drained();
        sample_ch.valid <= 1'b0;
        @(posedge clk);
        while (filtered_due_q.size() != 0) @(posedge clk);
    endtask

    initial begin
        stim_mode_t mode;
        int         run_len;
        t_sample    run_value;
        t_sample    s;
        bit         paused;
        paused = 1'b0;
        sample_ch.valid  <= 1'b0;
        sample_ch.sample <= '0;
        typed_flag       <= 1'b0;
        typed_value      <= '0;
        rst_n            <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            send_sample(directed_rows[i].sample, directed_rows[i].typed,
                        directed_rows[i].filtered);
        end
        wait_drained();

        while (n_sent < ITEM_COUNT) begin
            mode      = stim_mode_t'($urandom_range(0, 4));
            run_len   = (mode == MODE_CONSTANT) ? $urandom_range(64, 90)
                                                : $urandom_range(8, 48);
            run_value = ($urandom_range(0, 2) == 0) ? 12'hFFF
                      : ($urandom_range(0, 1) ? 12'h000 : t_sample'($urandom));
            for (int i = 0; i < run_len && n_sent < ITEM_COUNT; i++) begin
                case (mode)
                    MODE_UNIFORM: begin
                        s = t_sample'($urandom);
                    end
                    MODE_EXTREME: begin
                        s = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
                    end
                    MODE_SMALL: begin
                        s = t_sample'($urandom_range(0, 15));
                    end
                    MODE_CONSTANT: begin
                        s = run_value;
                    end
                    default: begin
                        s = (i % 2 == 0) ? run_value : ~run_value;
                    end
                endcase
                send_sample(s, 1'b0, '0);
            end
            if (!paused && n_sent >= ITEM_COUNT / 2) begin
                paused = 1'b1;
                wait_drained();
            end
        end

        sample_ch.valid <= 1'b0;
        @(posedge clk);
        while (filtered_due_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (n_errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+design
design/fir64_pkg.sv
design/fir64_if.sv
design/fir64_cell.sv
design/fir_filter_64_tap.sv
test/tb_fir_filter_64_tap.sv
